[rtl/sorted_table_binary_search_macros.svh]
// Assertion macros shared by the checker of the sorted table search block.
// No dependencies; take in with `include before any use.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sbs_pkg.sv]
// Shared constants and controller/datapath interface types for the sorted table search.
// No dependencies; compile first.
`default_nettype none

package sbs_pkg;

    localparam int IDX_W             = 10;
    localparam int VAL_W             = 32;
    localparam int TABLE_DEPTH_DEF   = 1024;
    localparam int ENTRY_WIDTH_DEF   = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;
        logic start;
        logic step;
        logic load_out;
    } sbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic stop;
    } sbs_status_t;

endpackage

`default_nettype wire

[rtl/sbs_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module sbs_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/sbs_ctrl.sv]
// Controller of the sorted table search: sequences accept, probes and result hand-off.
// Depends on sbs_pkg.
`default_nettype none

module sbs_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_action,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire sbs_pkg::sbs_status_t status,
    output sbs_pkg::sbs_cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action) begin
                        cmd.start  = 1'b1;
                        state_next = status.empty ? ST_DONE : ST_PROBE;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                cmd.step = 1'b1;
                if (status.stop) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[rtl/sbs_dpath.sv]
// Datapath of the sorted table search: bounds, midpoint, probe compare and result registers.
// Depends on sbs_pkg; drives the table RAM ports.
`default_nettype none

module sbs_dpath #(
    parameter  int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
    parameter  int ENTRY_WIDTH = sbs_pkg::ENTRY_WIDTH_DEF,
    localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic                              aclk,
    input  wire sbs_pkg::sbs_cmd_t                 cmd,
    output sbs_pkg::sbs_status_t                   status,
    input  wire logic        [sbs_pkg::IDX_W-1:0]  s_entry_index,
    input  wire logic signed [sbs_pkg::VAL_W-1:0]  s_entry_value,
    input  wire logic signed [sbs_pkg::VAL_W-1:0]  s_target,
    input  wire logic        [sbs_pkg::IDX_W-1:0]  s_range_low,
    input  wire logic        [sbs_pkg::IDX_W-1:0]  s_range_high,
    output logic                                   m_found,
    output logic             [sbs_pkg::IDX_W-1:0]  m_position,
    output logic                                   ram_wr_en,
    output logic             [AW-1:0]              ram_wr_addr,
    output logic             [ENTRY_WIDTH-1:0]     ram_wr_data,
    output logic             [AW-1:0]              ram_rd_addr,
    input  wire logic        [ENTRY_WIDTH-1:0]     ram_rd_data
);

    localparam int IW = sbs_pkg::IDX_W;
    // bounds carry a sign and one extra bit for mid + 1 and mid - 1
    localparam int SW = IW + 2;

    logic signed [ENTRY_WIDTH-1:0] key_reg;
    logic signed [SW-1:0]          lo_reg, hi_reg;
    logic        [IW-1:0]          mid_reg;
    logic                          hit_reg;
    logic        [IW-1:0]          pos_reg;
    logic                          m_found_reg;
    logic        [IW-1:0]          m_position_reg;

    logic        [IW-1:0]          in_lo, in_hi;
    logic        [IW:0]            in_sum;
    logic        [IW-1:0]          in_mid;
    logic signed [ENTRY_WIDTH-1:0] probe;
    logic                          probe_eq, probe_lt;
    logic signed [SW-1:0]          mid_ext, lo_step, hi_step, step_sum;
    logic        [IW-1:0]          step_mid;

    // saturate the range ends to the last table entry
    always_comb begin
        in_lo = s_range_low;
        in_hi = s_range_high;
        if (32'(s_range_low) > 32'(TABLE_DEPTH - 1)) begin
            in_lo = IW'(TABLE_DEPTH - 1);
        end
        if (32'(s_range_high) > 32'(TABLE_DEPTH - 1)) begin
            in_hi = IW'(TABLE_DEPTH - 1);
        end
    end

    assign in_sum = {1'b0, in_lo} + {1'b0, in_hi};
    assign in_mid = in_sum[IW:1];

    assign probe    = $signed(ram_rd_data);
    assign probe_eq = (probe == key_reg);
    assign probe_lt = (probe < key_reg);
    assign mid_ext  = SW'(mid_reg);

    always_comb begin
        lo_step = lo_reg;
        hi_step = hi_reg;
        priority if (probe_eq) begin
            lo_step = lo_reg;
        end else if (probe_lt) begin
            lo_step = mid_ext + SW'(1);
        end else begin
            hi_step = mid_ext - SW'(1);
        end
    end

    assign step_sum = lo_step + hi_step;
    assign step_mid = step_sum[IW:1];

    assign status.empty = (in_lo > in_hi);
    assign status.stop  = probe_eq || (lo_step > hi_step);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_reg <= ENTRY_WIDTH'(s_target);
            lo_reg  <= SW'(in_lo);
            hi_reg  <= SW'(in_hi);
            mid_reg <= in_mid;
            hit_reg <= 1'b0;
            pos_reg <= '0;
        end else if (cmd.step) begin
            lo_reg  <= lo_step;
            hi_reg  <= hi_step;
            mid_reg <= step_mid;
            if (probe_eq) begin
                hit_reg <= 1'b1;
                pos_reg <= mid_reg;
            end
        end
        if (cmd.load_out) begin
            m_found_reg    <= hit_reg;
            m_position_reg <= pos_reg;
        end
    end

    // drop writes beyond the table
    assign ram_wr_en   = cmd.write && (32'(s_entry_index) < 32'(TABLE_DEPTH));
    assign ram_wr_addr = AW'(s_entry_index);
    assign ram_wr_data = ENTRY_WIDTH'(s_entry_value);
    assign ram_rd_addr = cmd.step ? AW'(step_mid) : AW'(in_mid);

    assign m_found    = m_found_reg;
    assign m_position = m_position_reg;

endmodule

`default_nettype wire

[rtl/sorted_table_binary_search.sv]
// Sorted table binary search. A write transaction (s_action = 0) stores one signed entry
// in the table RAM in its accept cycle and returns nothing. A search transaction
// (s_action = 1) is accepted and then probes the table RAM, up to
// floor(log2(range_high - range_low + 1)) + 1 probes (11 for the full 1024-entry table),
// then moves the result into the output register once that register is free; an empty
// range goes straight to the result. The table RAM has a single read port, one read per
// probe. The next transaction is accepted once the result sits in the output register,
// even while it still waits for m_ready. The range must be sorted ascending; a miss or an
// empty range returns found = 0 and position = 0.
`default_nettype none

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF,
    parameter int ENTRY_WIDTH = sbs_pkg::ENTRY_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_action,
    input  wire logic        [sbs_pkg::IDX_W-1:0]  s_entry_index,
    input  wire logic signed [sbs_pkg::VAL_W-1:0]  s_entry_value,
    input  wire logic signed [sbs_pkg::VAL_W-1:0]  s_target,
    input  wire logic        [sbs_pkg::IDX_W-1:0]  s_range_low,
    input  wire logic        [sbs_pkg::IDX_W-1:0]  s_range_high,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_found,
    output logic             [sbs_pkg::IDX_W-1:0]  m_position
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    sbs_pkg::sbs_cmd_t    cmd;
    sbs_pkg::sbs_status_t status;

    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [ENTRY_WIDTH-1:0] ram_wr_data;
    logic [AW-1:0]          ram_rd_addr;
    logic [ENTRY_WIDTH-1:0] ram_rd_data;

    sbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dpath (
        .aclk          (aclk),
        .cmd           (cmd),
        .status        (status),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .s_target      (s_target),
        .s_range_low   (s_range_low),
        .s_range_high  (s_range_high),
        .m_found       (m_found),
        .m_position    (m_position),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data)
    );

    sbs_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

[rtl/sbs_checker.sv]
// Port-level checker for the sorted table search, bound to the top level.
// Depends on sorted_table_binary_search_macros.svh and sorted_table_binary_search.
`default_nettype none
`include "sorted_table_binary_search_macros.svh"

module sbs_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      s_action,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic                      m_found,
    input wire logic [sbs_pkg::IDX_W-1:0] m_position
);

    // a stalled result must hold
    `SBS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_found) && $stable(m_position), "result changed while stalled")

    `SBS_ASSERT_NOW(a_miss_zero, aclk, aresetn, m_valid && !m_found, m_position == '0, "miss with nonzero position")

    // a write transaction never produces a result
    `SBS_ASSERT_NEXT(a_write_silent, aclk, aresetn, s_valid && s_ready && !s_action && !m_valid, !m_valid, "result after write transaction")

    `SBS_ASSERT_NEXT(a_search_busy, aclk, aresetn, s_valid && s_ready && s_action, !s_ready, "ready right after search accept")

endmodule

bind sorted_table_binary_search sbs_checker u_sbs_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_action   (s_action),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_found    (m_found),
    .m_position (m_position)
);

`default_nettype wire
